// File: src/serpentine_led_frame_buffer_unit_defines.svh
// Assertion macros used by the checker file of the frame buffer.
`ifndef SERPENTINE_LED_FRAME_BUFFER_UNIT_DEFINES_SVH
`define SERPENTINE_LED_FRAME_BUFFER_UNIT_DEFINES_SVH

// Clocked assertion that is switched off while reset is high.
`define SLFB_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked assertion that also holds while reset is high.
`define SLFB_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: src/slfb_pkg.sv
package slfb_pkg;

   // Packed stream widths, padded to whole bytes.
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 32;

   // Field widths.
   localparam int X_W     = 6;
   localparam int Y_W     = 4;
   localparam int CHAN_W  = 8;
   localparam int POS_W   = 8;
   localparam int GRB_W   = 24;
   localparam int GAIN_W  = 9;

   // Wide enough for any strip index of the largest matrix, and for the store depth.
   localparam int IDX_W = X_W + Y_W + 1;

   // Gain after reset: 1.0 in Q1.8.
   localparam logic [GAIN_W-1:0] GAIN_RESET = 9'd256;

   // Request kinds carried on tuser.
   typedef enum logic [1:0] {
      REQ_SET       = 2'd0,
      REQ_CLEAR     = 2'd1,
      REQ_CLEAR_ALL = 2'd2,
      REQ_READ      = 2'd3
   } req_kind_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic do_write;
      logic do_clear;
      logic do_clear_all;
      logic do_read;
      logic load_rsp;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      req_kind_type kind;
      logic         out_free;
   } status_type;

endpackage

// File: src/slfb_ctrl.sv
module slfb_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  slfb_pkg::status_type status,
   output slfb_pkg::cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_EXEC = 3'b010,
      ST_RESP = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_tready = (state_ff == ST_IDLE);

   // Next state and command decode.
   always_comb begin
      state_in         = state_ff;
      cmd              = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
            case (status.kind)
               slfb_pkg::REQ_SET:       cmd.do_write     = 1'b1;
               slfb_pkg::REQ_CLEAR:     cmd.do_clear     = 1'b1;
               slfb_pkg::REQ_CLEAR_ALL: cmd.do_clear_all = 1'b1;
               slfb_pkg::REQ_READ: begin
                  cmd.do_read = 1'b1;
                  state_in    = ST_RESP;
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_RESP: begin
            // Wait until the result register can take the word.
            if (status.out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: src/slfb_datapath.sv
module slfb_datapath #(
   parameter int WIDTH_PX    = 32,
   parameter int HEIGHT_PX   = 8,
   parameter int PIXEL_COUNT = 256
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  slfb_pkg::cmd_type                    cmd,
   output slfb_pkg::status_type                 status,
   input  logic [1:0]                           req_tuser,
   input  logic [slfb_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic                                 csr_valid,
   input  logic [slfb_pkg::GAIN_W-1:0]          csr_data,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [slfb_pkg::RSP_DATA_W-1:0]      rsp_tdata
);

   // Reads only reach the first 256 strip positions, so nothing above is stored.
   localparam int STORE_DEPTH = (PIXEL_COUNT < 256) ? PIXEL_COUNT : 256;
   localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int IW          = slfb_pkg::IDX_W;

   slfb_pkg::req_kind_type         kind_ff;
   logic [slfb_pkg::X_W-1:0]       x_ff;
   logic [slfb_pkg::Y_W-1:0]       y_ff;
   logic [slfb_pkg::CHAN_W-1:0]    red_ff;
   logic [slfb_pkg::CHAN_W-1:0]    green_ff;
   logic [slfb_pkg::CHAN_W-1:0]    blue_ff;
   logic [slfb_pkg::POS_W-1:0]     pos_ff;
   logic [slfb_pkg::GAIN_W-1:0]    gain_ff;

   logic [slfb_pkg::X_W-1:0]       col;
   logic                           on_matrix;
   logic [IW-1:0]                  idx;
   logic                           in_store;
   logic                           pos_ok;
   logic [ADDR_W-1:0]              addr;
   logic [slfb_pkg::GRB_W-1:0]     wr_word;

   logic [slfb_pkg::GRB_W-1:0]     mem [STORE_DEPTH];
   logic [STORE_DEPTH-1:0]         valid_ff;
   logic [slfb_pkg::GRB_W-1:0]     rd_data_ff;
   logic                           rd_hit_ff;
   logic                           rsp_valid_ff;
   logic [slfb_pkg::RSP_DATA_W-1:0] rsp_data_ff;

   // Scale one channel by the Q1.8 gain, truncating and saturating at full scale.
   function automatic logic [7:0] scale_chan(input logic [7:0] v, input logic [8:0] g);
      logic [16:0] p;
      p = 17'(v) * 17'(g);
      return p[16] ? 8'hFF : p[15:8];
   endfunction

   // Capture the request; tdata bit 47 to 42 are padding.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff  <= slfb_pkg::req_kind_type'(req_tuser);
         x_ff     <= req_tdata[5:0];
         y_ff     <= req_tdata[9:6];
         red_ff   <= req_tdata[17:10];
         green_ff <= req_tdata[25:18];
         blue_ff  <= req_tdata[33:26];
         pos_ff   <= req_tdata[41:34];
      end
   end

   // Brightness gain register.
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= slfb_pkg::GAIN_RESET;
      end else if (csr_valid) begin
         gain_ff <= csr_data;
      end
   end

   // Serpentine mapping: mirrored column, even columns run bottom-up.
   always_comb begin
      on_matrix = (7'(x_ff) < 7'(WIDTH_PX)) && (5'(y_ff) < 5'(HEIGHT_PX));
      col       = slfb_pkg::X_W'(WIDTH_PX - 1) - x_ff;
      if (col[0]) begin
         idx = IW'(col) * IW'(HEIGHT_PX) + IW'(y_ff);
      end else begin
         idx = IW'(col) * IW'(HEIGHT_PX) + (IW'(HEIGHT_PX - 1) - IW'(y_ff));
      end
      in_store = on_matrix && (idx < IW'(STORE_DEPTH));
      pos_ok   = 9'(pos_ff) < 9'(STORE_DEPTH);
      addr     = cmd.do_read ? pos_ff[ADDR_W-1:0] : idx[ADDR_W-1:0];
      wr_word  = {scale_chan(green_ff, gain_ff), scale_chan(red_ff, gain_ff),
                  scale_chan(blue_ff, gain_ff)};
   end

   // Single-port pixel store with registered read.
   always_ff @(posedge clock) begin
      if (cmd.do_write && in_store) begin
         mem[addr] <= wr_word;
      end
      if (cmd.do_read) begin
         rd_data_ff <= mem[addr];
      end
   end

   // Valid bits: an entry that is not valid reads as zero.
   always_ff @(posedge clock) begin
      if (reset || cmd.do_clear_all) begin
         valid_ff <= '0;
      end else if (in_store && (cmd.do_write || cmd.do_clear)) begin
         valid_ff[addr] <= cmd.do_write;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.do_read) begin
         rd_hit_ff <= pos_ok && valid_ff[addr];
      end
   end

   // Result register; a new word may be loaded in the cycle the old one transfers.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_data_ff <= {pos_ff, rd_hit_ff ? rd_data_ff : slfb_pkg::GRB_W'(0)};
      end
   end

   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_tdata       = rsp_data_ff;
   assign status.kind     = kind_ff;
   assign status.out_free = !rsp_valid_ff || rsp_tready;

endmodule

// File: src/serpentine_led_frame_buffer_unit.sv
// Set, clear and clear-all requests are accepted by the controller, then update the store in its execute state.
// A read's result passes through the request capture registers, the registered memory read and the
// result register before it can transfer; it is held back beyond that only while the result port stalls.
// A new request is accepted once the previous one has left the controller, so requests never overlap.
// Synchronous active-high reset clears the valid bits, the result register and the controller
// and sets the gain to 1.0; the store is not cleared.
module serpentine_led_frame_buffer_unit #(
   parameter int WIDTH_PX    = 32,
   parameter int HEIGHT_PX   = 8,
   parameter int PIXEL_COUNT = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // req_type
   input  logic [1:0]                        req_tuser,
   // pos_x, pos_y, red, green, blue, strip_pos, zero padding
   input  logic [slfb_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // grb_word, read_pos
   output logic [slfb_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [slfb_pkg::GAIN_W-1:0]       csr_data
);

   slfb_pkg::cmd_type    cmd;
   slfb_pkg::status_type status;

   // The gain register takes a write in any cycle.
   assign csr_ready = 1'b1;

   slfb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   slfb_datapath #(
      .WIDTH_PX    (WIDTH_PX),
      .HEIGHT_PX   (HEIGHT_PX),
      .PIXEL_COUNT (PIXEL_COUNT)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// File: src/slfb_checker.sv
`include "serpentine_led_frame_buffer_unit_defines.svh"

module slfb_port_checks (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic [1:0]                        req_tuser,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [slfb_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   logic read_xfer;
   logic rsp_stall;

   assign read_xfer = req_tvalid && req_tready && (req_tuser == slfb_pkg::REQ_READ);
   assign rsp_stall = rsp_tvalid && !rsp_tready;

   // After reset no result is offered.
   `SLFB_ASSERT_ALWAYS(a_reset_idle, reset |=> !rsp_tvalid, "result valid after reset")

   // A stalled result is held.
   `SLFB_ASSERT(a_rsp_hold, rsp_stall |=> rsp_tvalid && $stable(rsp_tdata), "stalled result changed")

   // A fresh result follows a read transfer through the capture, memory read and result registers.
   `SLFB_ASSERT(a_rsp_source, $rose(rsp_tvalid) |-> $past(read_xfer, 3), "result without a read")

   // The block is busy in the cycle after a request transfer.
   `SLFB_ASSERT(a_busy, req_tvalid && req_tready |=> !req_tready, "request taken while busy")

endmodule

bind serpentine_led_frame_buffer_unit slfb_port_checks u_checker (.*);
